// File: rtl/core/vpc_pkg.sv
// Package for the variable power coil controller: shared types, constants,
// register codes, state encodings and the button and ramp step functions.
// No dependencies.
package vpc_pkg;

	localparam int unsigned COIL_MAX_MOHM = 50000;
	localparam int unsigned TAIL_STEP_MW  = 1800;
	localparam int unsigned RAMP_DEFINED  = 111;
	localparam int unsigned NUM_EDGES     = 14;
	localparam int unsigned LIMIT_RESET   = 75000;
	localparam int unsigned START_RESET   = 20000;
	localparam int unsigned VLIM_RESET    = 9000;
	localparam int unsigned WIN_RESET     = 60;
	localparam int unsigned VOLT_CAP_MV   = 65530;
	localparam int unsigned VOLT_ROUND_LO = 65525;
	localparam int unsigned VOLT_DOWN_MV  = 10;
	localparam int unsigned VOLT_UP_MV    = 100;
	localparam int unsigned ROUND_ADD     = 5;
	localparam int unsigned RECIP_10      = 52429;
	localparam int unsigned RECIP_SHIFT   = 19;
	localparam int unsigned SQ_STEPS      = 17;

	typedef logic [7:0]  ticks_t;
	typedef logic [10:0] step_t;
	typedef logic [16:0] mw_t;
	typedef logic [15:0] mv_t;

	typedef enum logic {OP_TICK, OP_POLL} op_t;

	typedef enum logic [1:0] {
		REG_POWER_LIMIT,
		REG_START_POWER,
		REG_VOLT_LIMIT,
		REG_TAP_WINDOW
	} cfg_reg_t;

	typedef struct packed {
		logic        op;
		logic        fire;
		logic        up;
		logic        down;
		logic [15:0] coil_mohm;
		logic        fault_free;
	} item_t;

	typedef struct packed {
		logic   held;
		ticks_t hold;
		ticks_t taps;
	} button_t;

	typedef struct packed {
		logic        start;
		logic [17:0] p;
		logic [15:0] r;
	} sq_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		mv_t  mv;
	} sq_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_UP, BK_UP_W, BK_DN, BK_DN_W, BK_TGT, BK_TGT_W, BK_EMIT
	} bk_state_t;

	typedef enum logic [1:0] {SQ_IDLE, SQ_MUL, SQ_ITER, SQ_ROUND} sq_state_t;

	// Hold times at which the rounded exponential ramp goes up by one step.
	localparam ticks_t RAMP_EDGES [NUM_EDGES] = '{
		8'd2, 8'd38, 8'd55, 8'd66, 8'd74, 8'd81, 8'd86,
		8'd91, 8'd95, 8'd99, 8'd102, 8'd105, 8'd108, 8'd110
	};

	function automatic step_t ramp_step(ticks_t t);
		logic [3:0] n;
		n = '0;
		if (t >= 8'(RAMP_DEFINED))
			return step_t'(TAIL_STEP_MW);
		for (int i = 0; i < NUM_EDGES; i++)
			if (t >= RAMP_EDGES[i])
				n = n + 4'd1;
		return step_t'(n) * step_t'(100);
	endfunction

	function automatic button_t track(logic pressed, button_t b, ticks_t w);
		button_t r;
		r = b;
		if (pressed) begin
			if (!b.held)
				r.hold = '0;
			if (r.hold > w)
				r.taps = '0;
			r.held = 1'b1;
		end else begin
			if (b.hold < w && b.held) begin
				if (b.taps != 8'hFF)
					r.taps = b.taps + 8'd1;
				r.hold = '0;
			end else if (b.held || b.hold > w) begin
				r.taps = '0;
			end
			r.held = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/vpc_if.sv
// Channel interfaces of the coil controller: item, result and register write.
// Each carries valid, ready and the payload. No dependencies.
interface vpc_item_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic        fire_button;
	logic        up_button;
	logic        down_button;
	logic [15:0] coil_mohm;
	logic        fault_free;
	modport source (output valid, op, fire_button, up_button, down_button, coil_mohm,
		fault_free, input ready);
	modport sink (input valid, op, fire_button, up_button, down_button, coil_mohm,
		fault_free, output ready);
endinterface

interface vpc_result_if;
	logic        valid;
	logic        ready;
	logic        output_enable;
	logic [15:0] output_mv;
	logic [16:0] power_mw;
	modport source (output valid, output_enable, output_mv, power_mw, input ready);
	modport sink (input valid, output_enable, output_mv, power_mw, output ready);
endinterface

interface vpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/vpc_front.sv
// Front end: accepts item beats, clamps the coil resistance and pushes the
// item into the queue. Depends on vpc_pkg and vpc_if.
module vpc_front import vpc_pkg::*; (
	vpc_item_if.sink item,
	input  logic     full,
	output logic     push,
	output item_t    wdata
);

	assign item.ready = !full;
	assign push       = item.valid && !full;

	always_comb begin
		wdata.op         = item.op;
		wdata.fire       = item.fire_button;
		wdata.up         = item.up_button;
		wdata.down       = item.down_button;
		wdata.fault_free = item.fault_free;
		wdata.coil_mohm  = (item.coil_mohm > 16'(COIL_MAX_MOHM)) ? 16'(COIL_MAX_MOHM)
			: item.coil_mohm;
	end

endmodule

// File: rtl/core/vpc_queue.sv
// Two-entry queue between the front end and the sequencer.
// Depends on vpc_pkg.
module vpc_queue import vpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

// File: rtl/core/vpc_isqrt.sv
// Voltage unit: registers P * R, takes its integer square root one bit a
// cycle and rounds it to 10 mV with a cap. Depends on vpc_pkg.
module vpc_isqrt import vpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  sq_req_t req,
	output sq_rsp_t rsp
);

	sq_state_t   state_q;
	logic [17:0] p_q;
	logic [15:0] r_q;
	logic [33:0] x_q;
	logic [19:0] rem_q;
	logic [16:0] root_q;
	logic [4:0]  cnt_q;
	mv_t         mv_q;
	logic        done_q;

	logic [19:0] rem_sh;
	logic [19:0] trial;
	logic        fits;
	logic [15:0] rnd;
	logic [31:0] prod;
	logic [12:0] quot;
	mv_t         mv_d;

	always_comb begin
		rem_sh = {rem_q[17:0], x_q[33:32]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = rem_sh >= trial;
		rnd    = root_q[15:0] + 16'(ROUND_ADD);
		prod   = 32'(rnd) * 32'(RECIP_10);
		quot   = prod[31:RECIP_SHIFT];
		// Roots that round to the cap or above are clamped before the divide.
		if (root_q >= 17'(VOLT_ROUND_LO))
			mv_d = mv_t'(VOLT_CAP_MV);
		else
			mv_d = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SQ_IDLE: if (req.start) state_q <= SQ_MUL;
				SQ_MUL: begin
					cnt_q   <= '0;
					state_q <= SQ_ITER;
				end
				SQ_ITER: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SQ_STEPS - 1))
						state_q <= SQ_ROUND;
				end
				SQ_ROUND: begin
					done_q  <= 1'b1;
					state_q <= SQ_IDLE;
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (req.start) begin
					p_q <= req.p;
					r_q <= req.r;
				end
			end
			SQ_MUL: begin
				x_q    <= 34'(p_q) * 34'(r_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			SQ_ITER: begin
				x_q <= {x_q[31:0], 2'b00};
				if (fits) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[15:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[15:0], 1'b0};
				end
			end
			SQ_ROUND: mv_q <= mv_d;
			default: ;
		endcase
	end

	assign rsp.busy = state_q != SQ_IDLE;
	assign rsp.done = done_q;
	assign rsp.mv   = mv_q;

endmodule

// File: rtl/core/vpc_back.sv
// Back end: holds the registers, button and power state, runs each poll item
// through the voltage unit and holds the result beat. Depends on vpc_pkg, vpc_if.
module vpc_back import vpc_pkg::*; #(
	parameter int unsigned RAMP_ENTRIES = 111
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   head,
	input  logic    q_empty,
	output logic    q_pop,
	vpc_cfg_if.sink cfg,
	vpc_result_if.source result,
	output sq_req_t sq_req,
	input  sq_rsp_t sq_rsp
);

	bk_state_t   state_q, state_d;
	mw_t         limit_q, power_q;
	mv_t         vlim_q, volt_q;
	ticks_t      win_q;
	button_t     btn_q [3];
	logic        coil_q;
	logic [15:0] res_q;
	step_t       step_up_q, step_dn_q;
	logic [17:0] op_q;
	logic        keep_q;
	logic        out_valid_q, out_enable_q;
	mv_t         out_mv_q;
	mw_t         out_power_q;

	button_t     nb [3];
	logic        press [3];
	logic        blocked, coil_n, emit_ok;
	logic [17:0] sum;
	logic        up_clamp, dn_zero;
	mv_t         tgt;

	function automatic step_t step_of(ticks_t t);
		if ({1'b0, t} >= 9'(RAMP_ENTRIES))
			return step_t'(TAIL_STEP_MW);
		return ramp_step(t);
	endfunction

	assign press[0] = head.fire;
	assign press[1] = head.up;
	assign press[2] = head.down;

	always_comb begin
		for (int i = 0; i < 3; i++)
			nb[i] = track(press[i], btn_q[i], win_q);
		blocked = nb[0].taps > 8'd1 && nb[0].hold < win_q;
		coil_n  = coil_q;
		if (!coil_q && nb[0].held && head.coil_mohm != 16'd0 && !blocked && head.fault_free)
			coil_n = 1'b1;
		else if ((coil_q && !nb[0].held) || blocked)
			coil_n = 1'b0;
		sum      = {1'b0, power_q} + 18'(step_up_q);
		up_clamp = sum >= {1'b0, limit_q};
		dn_zero  = 17'(step_dn_q) >= power_q;
		// While the coil is on the voltage only walks toward the target.
		tgt = sq_rsp.mv;
		if (sq_rsp.mv != volt_q && coil_q) begin
			if (sq_rsp.mv < volt_q)
				tgt = (volt_q >= mv_t'(VOLT_DOWN_MV)) ? volt_q - mv_t'(VOLT_DOWN_MV) : volt_q;
			else
				tgt = (17'(volt_q) + 17'(VOLT_UP_MV) > 17'hFFFF) ? 16'hFFFF
					: volt_q + mv_t'(VOLT_UP_MV);
		end
	end

	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		sq_req.start = 1'b0;
		sq_req.r     = res_q;
		sq_req.p     = {1'b0, power_q};
		emit_ok      = !out_valid_q || result.ready;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (head.op == OP_POLL)
						state_d = nb[1].held ? BK_UP : (nb[2].held ? BK_DN : BK_TGT);
					else
						state_d = BK_EMIT;
				end
			end
			BK_UP: begin
				sq_req.start = 1'b1;
				sq_req.p     = up_clamp ? {1'b0, limit_q} : sum;
				state_d      = BK_UP_W;
			end
			BK_UP_W: if (sq_rsp.done) state_d = btn_q[2].held ? BK_DN : BK_TGT;
			BK_DN: begin
				sq_req.p = {1'b0, power_q - 17'(step_dn_q)};
				if (dn_zero) begin
					state_d = BK_TGT;
				end else begin
					sq_req.start = 1'b1;
					state_d      = BK_DN_W;
				end
			end
			BK_DN_W: if (sq_rsp.done) state_d = BK_TGT;
			BK_TGT: begin
				sq_req.start = 1'b1;
				state_d      = BK_TGT_W;
			end
			BK_TGT_W: if (sq_rsp.done) state_d = BK_EMIT;
			BK_EMIT: if (emit_ok) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			limit_q <= mw_t'(LIMIT_RESET);
			power_q <= mw_t'(START_RESET);
			vlim_q  <= mv_t'(VLIM_RESET);
			win_q   <= ticks_t'(WIN_RESET);
			volt_q  <= '0;
			coil_q  <= 1'b0;
			for (int i = 0; i < 3; i++)
				btn_q[i] <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_IDLE: begin
					if (!q_empty) begin
						if (head.op == OP_POLL) begin
							for (int i = 0; i < 3; i++)
								btn_q[i] <= nb[i];
							coil_q <= coil_n;
						end else begin
							for (int i = 0; i < 3; i++)
								if (btn_q[i].hold != 8'hFF)
									btn_q[i].hold <= btn_q[i].hold + 8'd1;
						end
					end
				end
				BK_UP: if (up_clamp) power_q <= limit_q;
				BK_UP_W, BK_DN_W: begin
					if (sq_rsp.done) begin
						volt_q <= sq_rsp.mv;
						if (keep_q && sq_rsp.mv <= vlim_q)
							power_q <= op_q[16:0];
					end
				end
				BK_DN: begin
					if (dn_zero) begin
						power_q <= '0;
						volt_q  <= '0;
					end
				end
				BK_TGT_W: if (sq_rsp.done) volt_q <= tgt;
				default: ;
			endcase
			if (cfg.valid) begin
				case (cfg.index)
					REG_POWER_LIMIT: limit_q <= cfg.data;
					// The start power only matters at the moment it is written.
					REG_START_POWER: power_q <= cfg.data;
					REG_VOLT_LIMIT: vlim_q <= cfg.data[15:0];
					REG_TAP_WINDOW: win_q <= cfg.data[7:0];
					default: ;
				endcase
			end
		end
	end

	// Item payload and operands need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && head.op == OP_POLL) begin
					res_q     <= head.coil_mohm;
					step_up_q <= step_of(nb[1].hold);
					step_dn_q <= step_of(nb[2].hold);
				end
			end
			BK_UP: begin
				op_q   <= sq_req.p;
				keep_q <= !up_clamp;
			end
			BK_DN: begin
				op_q   <= sq_req.p;
				keep_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == BK_EMIT && emit_ok)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_EMIT && emit_ok) begin
			out_enable_q <= coil_q;
			out_mv_q     <= volt_q;
			out_power_q  <= power_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.output_enable = out_enable_q;
	assign result.output_mv     = out_mv_q;
	assign result.power_mw      = out_power_q;

endmodule

// File: rtl/core/variable_power_coil_controller.sv
// Top level of the variable power coil controller: front end, queue,
// sequencer and voltage unit. Depends on vpc_pkg, vpc_if and the vpc modules.
//
//   channel  role    payload
//   item     sink    op, fire/up/down buttons, coil_mohm, fault_free
//   result   source  output_enable, output_mv, power_mw
//   cfg      sink    index (2 bit), data (17 bit), always ready
//
// A tick passes from the sequencer's idle state straight to its emit state. A poll
// does one to three square roots, each a multiply state, the 17-step bit-serial
// square root and a rounding state in the voltage unit. Items also pass through the
// queue and the result register.
// The queue holds two items, so the front keeps accepting until it is full while a result beat
// waits; reset is asynchronous and active low and needs no clearing pass.
module variable_power_coil_controller import vpc_pkg::*; #(
	parameter int unsigned RAMP_ENTRIES = 111
) (
	input logic clk,
	input logic arst_n,
	vpc_item_if.sink item,
	vpc_result_if.source result,
	vpc_cfg_if.sink cfg
);

	logic    q_push, q_pop, q_full, q_empty;
	item_t   q_wdata, q_head;
	sq_req_t sq_req;
	sq_rsp_t sq_rsp;

	vpc_front u_front (
		.item  (item),
		.full  (q_full),
		.push  (q_push),
		.wdata (q_wdata)
	);

	vpc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.head  (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	vpc_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sq_req),
		.rsp   (sq_rsp)
	);

	vpc_back #(.RAMP_ENTRIES(RAMP_ENTRIES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.cfg    (cfg),
		.result (result),
		.sq_req (sq_req),
		.sq_rsp (sq_rsp)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue push while full");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue pop while empty");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sq_req.start |-> !sq_rsp.busy) else $error("square root started while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sq_req.start |=> sq_rsp.busy && !sq_req.start) else $error("square root not taken");

endmodule

// File: dv/tb_variable_power_coil_controller.sv
// Testbench for the variable power coil controller: drives tick and poll beats,
// predicts every result beat in a scoreboard class and checks them in order.
// Depends on vpc_pkg, vpc_if and the controller RTL.
`timescale 1ns / 1ps

module tb_variable_power_coil_controller import vpc_pkg::*; ();

	localparam int unsigned RAMP_N    = 111;
	localparam int unsigned WDOG_MAX  = 5000;
	localparam int unsigned SETTLE    = 100;
	localparam int unsigned HOLD_OFF  = 400;
	localparam int unsigned EDGE_T [14] = '{2, 38, 55, 66, 74, 81, 86, 91, 95, 99, 102,
		105, 108, 110};

	logic clk;
	logic arst_n;
	int   errors;
	int   polls_sent;
	int   ticks_sent;
	int   results_seen;
	int   idle_cycles;
	bit   hold_req;

	vpc_item_if   item ();
	vpc_result_if result ();
	vpc_cfg_if    cfg ();

	variable_power_coil_controller #(.RAMP_ENTRIES(RAMP_N)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	typedef struct {
		logic en;
		mv_t  mv;
		mw_t  pw;
	} coil_out_t;

	task automatic report(string what, int unsigned got, int unsigned want);
		errors++;
		$display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
	endtask

	class coil_scoreboard;
		int unsigned lim_mw, start_mw, vlim_mv, win;
		int unsigned hold [3];
		bit          held [3];
		int unsigned taps [3];
		bit          on;
		int unsigned pw, mv;
		coil_out_t   pending [$];

		function new();
			lim_mw = LIMIT_RESET;
			start_mw = START_RESET;
			vlim_mv = VLIM_RESET;
			win = WIN_RESET;
			for (int i = 0; i < 3; i++) begin
				hold[i] = 0;
				held[i] = 0;
				taps[i] = 0;
			end
			on = 0;
			pw = start_mw;
			mv = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, int unsigned val);
			case (idx)
				REG_POWER_LIMIT: lim_mw = val & 32'h1FFFF;
				REG_START_POWER: begin
					start_mw = val & 32'h1FFFF;
					pw = start_mw;
				end
				REG_VOLT_LIMIT: vlim_mv = val & 32'hFFFF;
				REG_TAP_WINDOW: win = val & 32'hFF;
				default: ;
			endcase
		endfunction

		function longint unsigned root(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 40;
			while (b > x)
				b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function int unsigned volts(int unsigned p, int unsigned r);
			longint unsigned s;
			s = root(longint'(p) * longint'(r));
			s = (s + 5) / 10 * 10;
			return (s > VOLT_CAP_MV) ? VOLT_CAP_MV : int'(s);
		endfunction

		function int unsigned ramp_mw(int unsigned t);
			int unsigned n;
			n = 0;
			if (t >= RAMP_N || t >= RAMP_DEFINED)
				return TAIL_STEP_MW;
			foreach (EDGE_T[i])
				if (t >= EDGE_T[i])
					n++;
			return n * 100;
		endfunction

		function void track_btn(int b, bit pressed);
			if (pressed) begin
				if (!held[b])
					hold[b] = 0;
				if (hold[b] > win)
					taps[b] = 0;
				held[b] = 1;
			end else begin
				if (hold[b] < win && held[b]) begin
					if (taps[b] < 255)
						taps[b]++;
					hold[b] = 0;
				end else if (held[b] || hold[b] > win) begin
					taps[b] = 0;
				end
				held[b] = 0;
			end
		endfunction

		function void note_item(op_t op, bit f, bit u, bit d, int unsigned coil, bit ok);
			int unsigned res, sum, nv, dec, tgt;
			bit          blocked;
			coil_out_t   o;
			if (op == OP_TICK) begin
				for (int i = 0; i < 3; i++)
					if (hold[i] < 255)
						hold[i]++;
			end else begin
				res = (coil > COIL_MAX_MOHM) ? COIL_MAX_MOHM : coil;
				track_btn(0, f);
				track_btn(1, u);
				track_btn(2, d);
				blocked = taps[0] > 1 && hold[0] < win;
				if (!on && held[0] && res != 0 && !blocked && ok)
					on = 1;
				else if ((on && !held[0]) || blocked)
					on = 0;
				if (held[1]) begin
					sum = pw + ramp_mw(hold[1]);
					nv = volts(sum, res);
					if (sum >= lim_mw) begin
						pw = lim_mw;
						nv = volts(pw, res);
					end else if (nv <= vlim_mv) begin
						pw = sum;
					end
					mv = nv;
				end
				if (held[2]) begin
					dec = ramp_mw(hold[2]);
					if (dec >= pw) begin
						pw = 0;
						nv = 0;
					end else begin
						nv = volts(pw - dec, res);
						if (nv <= vlim_mv)
							pw -= dec;
					end
					mv = nv;
				end
				tgt = volts(pw, res);
				// While the coil is on the voltage only creeps toward the target.
				if (tgt != mv && on) begin
					if (tgt < mv)
						tgt = (mv >= 10) ? mv - 10 : mv;
					else
						tgt = (mv + 100 > 65535) ? 65535 : mv + 100;
				end
				mv = tgt;
			end
			o.en = on;
			o.mv = mv_t'(mv);
			o.pw = mw_t'(pw);
			pending.push_back(o);
		endfunction

		task check_result(logic en, mv_t v, mw_t p);
			coil_out_t w;
			if (pending.size() == 0) begin
				report("unexpected result beat", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (en !== w.en)
				report("output_enable", en, w.en);
			if (v !== w.mv)
				report("output_mv", v, w.mv);
			if (p !== w.pw)
				report("power_mw", p, w.pw);
		endtask
	endclass

	coil_scoreboard sb = new();

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.op = OP_TICK;
		item.fire_button = 1'b0;
		item.up_button = 1'b0;
		item.down_button = 1'b0;
		item.coil_mohm = '0;
		item.fault_free = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_POWER_LIMIT;
		cfg.data = '0;
		result.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Result side: random stalls, mostly short, and one long hold-off on request.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				result.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
				result.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 25) begin
				result.ready <= 1'b0;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
				repeat (n) @(posedge clk);
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			sb.check_result(result.output_enable, result.output_mv, result.power_mw);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_MAX) begin
			$display("Watchdog: no beat for %0d cycles", WDOG_MAX);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Valid stays high across back-to-back beats; callers drop it with gap().
	task automatic send(op_t op, bit f, bit u, bit d, int unsigned coil, bit ok);
		item.valid <= 1'b1;
		item.op <= op;
		item.fire_button <= f;
		item.up_button <= u;
		item.down_button <= d;
		item.coil_mohm <= coil[15:0];
		item.fault_free <= ok;
		do @(posedge clk); while (!item.ready);
		sb.note_item(op, f, u, d, coil & 32'hFFFF, ok);
		if (op == OP_TICK)
			ticks_sent++;
		else
			polls_sent++;
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			item.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			gap(0);
		else if (r < 95)
			gap($urandom_range(1, 5));
		else
			gap($urandom_range(20, 200));
	endtask

	task automatic drain();
		gap(1);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(int unsigned lim, int unsigned st, int unsigned vl, int unsigned w);
		int unsigned vals [4];
		vals = '{lim, st, vl, w};
		for (int i = 0; i < 4; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= cfg_reg_t'(i);
			cfg.data <= vals[i][16:0];
			do @(posedge clk); while (!cfg.ready);
			sb.write_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int unsigned pick_coil();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		if (r < 10)
			return $urandom_range(50001, 65535);
		if (r < 15)
			return $urandom_range(0, 65535);
		return $urandom_range(100, 3000);
	endfunction

	task automatic random_items(int count);
		bit f, u, d;
		int r, sent;
		f = 0;
		u = 0;
		d = 0;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				// A long run of ticks lets hold timers climb the whole ramp.
				repeat ($urandom_range(20, 140)) begin
					send(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 1));
					sent++;
				end
			end else if (r < 50) begin
				send(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 1));
				sent++;
			end else begin
				if ($urandom_range(0, 99) < 25) f = ~f;
				if ($urandom_range(0, 99) < 12) u = ~u;
				if ($urandom_range(0, 99) < 12) d = ~d;
				send(OP_POLL, f, u, d, pick_coil(), $urandom_range(0, 99) < 85);
				sent++;
			end
			random_gap();
		end
	endtask

	initial begin
		errors = 0;
		polls_sent = 0;
		ticks_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		hold_req = 0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed: extremes, fire taps, fault, overflow and underflow.
		send(OP_TICK, 1, 1, 1, 65535, 1);
		send(OP_POLL, 0, 0, 0, 0, 0);
		send(OP_POLL, 1, 0, 0, 0, 1);
		send(OP_POLL, 1, 0, 0, 500, 0);
		send(OP_POLL, 1, 0, 0, 500, 1);
		send(OP_POLL, 1, 0, 0, 500, 0);
		send(OP_POLL, 1, 1, 0, 500, 1);
		send(OP_POLL, 1, 0, 1, 500, 1);
		send(OP_POLL, 0, 0, 0, 500, 1);
		send(OP_POLL, 1, 0, 0, 500, 1);
		send(OP_POLL, 0, 0, 0, 500, 1);
		send(OP_POLL, 1, 0, 0, 500, 1);
		send(OP_POLL, 0, 1, 1, 65535, 1);
		send(OP_POLL, 0, 1, 0, 50000, 1);
		repeat (120) send(OP_TICK, 0, 0, 0, 0, 0);
		send(OP_POLL, 0, 1, 0, 50001, 1);
		send(OP_POLL, 0, 0, 1, 200, 1);
		drain();

		write_regs(100000, 100000, 65535, 254);
		send(OP_POLL, 0, 1, 0, 65535, 1);
		send(OP_POLL, 1, 0, 1, 65535, 1);
		drain();
		write_regs(1000, 0, 0, 1);
		send(OP_POLL, 0, 0, 1, 1000, 1);
		send(OP_POLL, 0, 1, 0, 1000, 1);
		drain();

		// Random phases under different settings.
		write_regs(LIMIT_RESET, START_RESET, VLIM_RESET, WIN_RESET);
		random_items(250);
		hold_req = 1;
		random_items(50);
		drain();
		write_regs(100000, 100000, 65535, 254);
		random_items(200);
		drain();
		write_regs(1000, 0, 0, 1);
		random_items(150);
		drain();
		write_regs($urandom_range(1000, 100000), $urandom_range(0, 100000),
			$urandom_range(3000, 20000), $urandom_range(2, 120));
		random_items(200);
		drain();
		write_regs(50000, 1500, 12000, 10);
		random_items(200);
		drain();

		$display("Covered %0d polls and %0d ticks over five register settings,", polls_sent,
			ticks_sent);
		$display("%0d result beats checked, %0d mismatches.", results_seen, errors);
		if (errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/vpc_pkg.sv
rtl/core/vpc_if.sv
rtl/core/vpc_front.sv
rtl/core/vpc_queue.sv
rtl/core/vpc_isqrt.sv
rtl/core/vpc_back.sv
rtl/core/variable_power_coil_controller.sv
dv/tb_variable_power_coil_controller.sv
